// File: rtl/hcbd_pkg.sv
package hcbd_pkg;

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 31;
    localparam int STATUS_W = 3;

    // item kinds on the receive stream
    localparam logic [MODE_W-1:0] MODE_BYTE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd2;

    // end status codes
    localparam logic [STATUS_W-1:0] STAT_CONT     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_LINE_LEN = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_CRLF  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_MSG   = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_VT  = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SP  = 8'h20;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BYTE_W-1:0]   byte_in;
        logic [LENGTH_W-1:0] body_length;
    } in_item_t;

    typedef struct packed {
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] end_status;
    } out_item_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(logic [BYTE_W-1:0] b);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = b[3:0];
        if (b inside {[8'h30:8'h39]})
        begin
            d.value = b[3:0];
        end
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            // letters share the low nibble pattern: a/A = 1 -> 10
            d.value = 4'(b[3:0] + 4'd9);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_blank(logic [BYTE_W-1:0] b);
        return b inside {CHAR_SP, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    endfunction

endpackage

// File: rtl/hcbd_stream_if.sv
interface hcbd_stream_if;
    logic                           valid;
    logic                           ready;
    logic [hcbd_pkg::MODE_W-1:0]    mode;
    logic [hcbd_pkg::BYTE_W-1:0]    byte_in;
    logic [hcbd_pkg::LENGTH_W-1:0]  body_length;

    modport source (output valid, output mode, output byte_in, output body_length,
                    input ready);
    modport sink   (input valid, input mode, input byte_in, input body_length,
                    output ready);
endinterface

// File: rtl/hcbd_result_if.sv
interface hcbd_result_if;
    logic                           valid;
    logic                           ready;
    logic                           payload_valid;
    logic [hcbd_pkg::BYTE_W-1:0]    payload_byte;
    logic [hcbd_pkg::STATUS_W-1:0]  end_status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output end_status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input end_status, output ready);
endinterface

// File: rtl/hcbd_in_reg.sv
module hcbd_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    hcbd_stream_if.sink        stream,
    output logic               item_valid,
    output hcbd_pkg::in_item_t item,
    input  logic               item_ready
);

    logic               valid_reg;
    hcbd_pkg::in_item_t item_reg;
    logic               load;

    assign stream.ready = !valid_reg || item_ready;
    assign load         = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mode        <= stream.mode;
            item_reg.byte_in     <= stream.byte_in;
            item_reg.body_length <= stream.body_length;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/hcbd_deframe.sv
module hcbd_deframe #(
    parameter int LINE_LIMIT = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  hcbd_pkg::in_item_t  item,
    output logic                item_ready,
    output logic                res_valid,
    output hcbd_pkg::out_item_t res,
    input  logic                res_ready
);

    localparam int LB_W  = $clog2(LINE_LIMIT + 1);
    localparam int CNT_W = (SIZE_BITS > hcbd_pkg::LENGTH_W) ? SIZE_BITS : hcbd_pkg::LENGTH_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_LEAD,
        PH_HEX,
        PH_DATA,
        PH_TCR,
        PH_TLF
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [LB_W-1:0]      line_bytes_reg, line_bytes_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic                 hex_stopped_reg, hex_stopped_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic [CNT_W-1:0]     bytes_left_reg, bytes_left_next;
    logic                 res_valid_reg;
    hcbd_pkg::out_item_t  res_reg, res_next;

    logic                 step;
    logic [hcbd_pkg::BYTE_W-1:0] b;
    hcbd_pkg::hex_digit_t digit;
    logic [LB_W-1:0]      lb_inc;
    logic                 last_byte;
    logic                 got_crlf;
    logic [SIZE_BITS-1:0] accum_shifted;

    assign item_ready = !res_valid_reg || res_ready;
    assign step       = item_valid && item_ready;

    assign b         = item.byte_in;
    assign digit     = hcbd_pkg::hex_decode(b);
    assign lb_inc    = line_bytes_reg + LB_W'(1);
    assign last_byte = (bytes_left_reg == CNT_W'(1));
    assign got_crlf  = prev_cr_reg && (b == hcbd_pkg::CHAR_LF);

    // the accumulator saturates to all ones once the top nibble is set, since another digit would overflow
    always_comb
    begin
        if (|size_accum_reg[SIZE_BITS-1 -: 4])
        begin
            accum_shifted = '1;
        end
        else
        begin
            accum_shifted = {size_accum_reg[SIZE_BITS-5:0], digit.value};
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        line_bytes_next  = line_bytes_reg;
        prev_cr_next     = prev_cr_reg;
        hex_stopped_next = hex_stopped_reg;
        size_accum_next  = size_accum_reg;
        bytes_left_next  = bytes_left_reg;
        res_next         = '0;

        case (item.mode)
            hcbd_pkg::MODE_FIXED:
            begin
                if (item.body_length == '0)
                begin
                    phase_next          = PH_IDLE;
                    res_next.end_status = hcbd_pkg::STAT_COMPLETE;
                end
                else
                begin
                    bytes_left_next = CNT_W'(item.body_length);
                    phase_next      = PH_FIXED;
                end
            end
            hcbd_pkg::MODE_CHUNKED:
            begin
                phase_next       = PH_LEAD;
                line_bytes_next  = '0;
                prev_cr_next     = 1'b0;
                hex_stopped_next = 1'b0;
                size_accum_next  = '0;
            end
            hcbd_pkg::MODE_BYTE:
            begin
                case (phase_reg)
                    PH_FIXED:
                    begin
                        res_next.payload_valid = 1'b1;
                        res_next.payload_byte  = b;
                        bytes_left_next        = bytes_left_reg - CNT_W'(1);
                        if (last_byte)
                        begin
                            phase_next          = PH_IDLE;
                            res_next.end_status = hcbd_pkg::STAT_COMPLETE;
                        end
                    end
                    PH_LEAD, PH_HEX:
                    begin
                        line_bytes_next = lb_inc;
                        if (got_crlf)
                        begin
                            if (size_accum_reg == '0)
                            begin
                                phase_next          = PH_IDLE;
                                res_next.end_status = hcbd_pkg::STAT_COMPLETE;
                            end
                            else
                            begin
                                bytes_left_next = CNT_W'(size_accum_reg);
                                phase_next      = PH_DATA;
                            end
                        end
                        else
                        begin
                            if (!hex_stopped_reg)
                            begin
                                if (digit.is_hex)
                                begin
                                    size_accum_next = accum_shifted;
                                    phase_next      = PH_HEX;
                                end
                                else if (!(phase_reg == PH_LEAD && hcbd_pkg::is_blank(b)))
                                begin
                                    hex_stopped_next = 1'b1;
                                end
                            end
                            prev_cr_next = (b == hcbd_pkg::CHAR_CR);
                            if (lb_inc >= LB_W'(LINE_LIMIT))
                            begin
                                phase_next          = PH_IDLE;
                                res_next.end_status = hcbd_pkg::STAT_LINE_LEN;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        res_next.payload_valid = 1'b1;
                        res_next.payload_byte  = b;
                        bytes_left_next        = bytes_left_reg - CNT_W'(1);
                        if (last_byte)
                        begin
                            phase_next = PH_TCR;
                        end
                    end
                    PH_TCR:
                    begin
                        prev_cr_next = (b == hcbd_pkg::CHAR_CR);
                        phase_next   = PH_TLF;
                    end
                    PH_TLF:
                    begin
                        if (got_crlf)
                        begin
                            phase_next       = PH_LEAD;
                            line_bytes_next  = '0;
                            prev_cr_next     = 1'b0;
                            hex_stopped_next = 1'b0;
                            size_accum_next  = '0;
                        end
                        else
                        begin
                            phase_next          = PH_IDLE;
                            res_next.end_status = hcbd_pkg::STAT_NO_CRLF;
                        end
                    end
                    default:
                    begin
                        res_next.end_status = hcbd_pkg::STAT_NO_MSG;
                    end
                endcase
            end
            default:
            begin
                // unused mode: all-zero result, state untouched
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            line_bytes_reg  <= '0;
            prev_cr_reg     <= 1'b0;
            hex_stopped_reg <= 1'b0;
            size_accum_reg  <= '0;
            bytes_left_reg  <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
            if (step)
            begin
                phase_reg       <= phase_next;
                line_bytes_reg  <= line_bytes_next;
                prev_cr_reg     <= prev_cr_next;
                hex_stopped_reg <= hex_stopped_next;
                size_accum_reg  <= size_accum_next;
                bytes_left_reg  <= bytes_left_next;
                res_reg         <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/http_chunked_body_decoder.sv
// HTTP/1.1 body deframer: takes one transaction per cycle on stream while result is
// not stalled (a body byte or an open command for a fixed-length or chunked body) and
// returns exactly one result transaction for each, in order; the input register and
// the result register sit on either side of the parsing logic, so throughput is one
// item per clock with no dead cycles while result is not stalled.
// Chunk size lines are parsed as hexadecimal, saturating at 2^SIZE_BITS-1, and a line
// that reaches LINE_LIMIT bytes without CR LF ends the message with a length error.
// Trailers after the final zero-size chunk are not consumed and report as bytes with
// no open message.
module http_chunked_body_decoder #(
    parameter int LINE_LIMIT = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    hcbd_stream_if.sink   stream,
    hcbd_result_if.source result
);

    logic                item_valid;
    logic                item_ready;
    hcbd_pkg::in_item_t  item;
    hcbd_pkg::out_item_t res;

    hcbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    hcbd_deframe #(
        .LINE_LIMIT (LINE_LIMIT),
        .SIZE_BITS  (SIZE_BITS)
    ) u_deframe (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (result.valid),
        .res        (res),
        .res_ready  (result.ready)
    );

    assign result.payload_valid = res.payload_valid;
    assign result.payload_byte  = res.payload_byte;
    assign result.end_status    = res.end_status;

    // a payload byte never carries an error status
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload_valid) |->
            (result.end_status == hcbd_pkg::STAT_CONT ||
             result.end_status == hcbd_pkg::STAT_COMPLETE))
        else $error("payload byte with error status");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.payload_valid) |-> (result.payload_byte == '0))
        else $error("payload byte not cleared");

    // an empty input register or an empty result register always leaves stream ready
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!item_valid || !result.valid) |-> stream.ready)
        else $error("stream stalled with free storage");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.end_status <= hcbd_pkg::STAT_NO_MSG))
        else $error("end status out of range");

endmodule

// File: dv/hcbd_body_checker.sv
module hcbd_body_checker #(
    parameter int LINE_LIMIT = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    hcbd_stream_if stream,
    hcbd_result_if result,
    output int     fail_count,
    output int     pending,
    output int     items_seen,
    output int     payload_seen,
    output int     complete_seen,
    output int     error_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W   = hcbd_pkg::BYTE_W;
    localparam int STATUS_W = hcbd_pkg::STATUS_W;

    typedef enum logic [2:0] {
        BODY_IDLE,
        BODY_FIXED,
        LINE_LEAD,
        LINE_HEX,
        CHUNK_DATA,
        TRAIL_CR,
        TRAIL_LF
    } body_phase_e;

    localparam logic [SIZE_BITS-1:0] SIZE_CAP = '1;

    body_phase_e          phase_q;
    int                   line_cnt_q;
    logic                 cr_q;
    logic                 stopped_q;
    logic [SIZE_BITS-1:0] size_q;
    logic [63:0]          left_q;

    hcbd_pkg::out_item_t due_results[$];
    hcbd_pkg::in_item_t  taken;
    hcbd_pkg::out_item_t want;
    hcbd_pkg::out_item_t got;

    function automatic int hex_nibble(logic [BYTE_W-1:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b) - 'h30;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b) - 'h57;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b) - 'h37;
        end
        return -1;
    endfunction

    function automatic logic blank_byte(logic [BYTE_W-1:0] b);
        return b == hcbd_pkg::CHAR_SP || b == hcbd_pkg::CHAR_TAB || b == hcbd_pkg::CHAR_LF
            || b == hcbd_pkg::CHAR_VT || b == hcbd_pkg::CHAR_FF || b == hcbd_pkg::CHAR_CR;
    endfunction

    function automatic void open_size_line();
        phase_q    = LINE_LEAD;
        line_cnt_q = 0;
        cr_q       = 1'b0;
        stopped_q  = 1'b0;
        size_q     = '0;
    endfunction

    function automatic logic [STATUS_W-1:0] size_line_byte(logic [BYTE_W-1:0] b);
        int d;
        line_cnt_q++;
        if (cr_q && b == hcbd_pkg::CHAR_LF)
        begin
            if (size_q == '0)
            begin
                phase_q = BODY_IDLE;
                return hcbd_pkg::STAT_COMPLETE;
            end
            left_q  = 64'(size_q);
            phase_q = CHUNK_DATA;
            return hcbd_pkg::STAT_CONT;
        end
        if (!stopped_q)
        begin
            d = hex_nibble(b);
            if (d >= 0)
            begin
                // saturate once another digit would overflow
                if (size_q > (SIZE_CAP >> 4))
                begin
                    size_q = SIZE_CAP;
                end
                else
                begin
                    size_q = (size_q << 4) | SIZE_BITS'(d);
                end
                phase_q = LINE_HEX;
            end
            else if (!(phase_q == LINE_LEAD && blank_byte(b)))
            begin
                stopped_q = 1'b1;
            end
        end
        cr_q = (b == hcbd_pkg::CHAR_CR);
        if (line_cnt_q >= LINE_LIMIT)
        begin
            phase_q = BODY_IDLE;
            return hcbd_pkg::STAT_LINE_LEN;
        end
        return hcbd_pkg::STAT_CONT;
    endfunction

    function automatic hcbd_pkg::out_item_t deframe_step(hcbd_pkg::in_item_t it);
        hcbd_pkg::out_item_t r;
        r = '0;
        case (it.mode)
            hcbd_pkg::MODE_FIXED:
            begin
                if (it.body_length == '0)
                begin
                    phase_q      = BODY_IDLE;
                    r.end_status = hcbd_pkg::STAT_COMPLETE;
                end
                else
                begin
                    left_q  = 64'(it.body_length);
                    phase_q = BODY_FIXED;
                end
            end
            hcbd_pkg::MODE_CHUNKED:
            begin
                open_size_line();
            end
            hcbd_pkg::MODE_BYTE:
            begin
                case (phase_q)
                    BODY_FIXED, CHUNK_DATA:
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = it.byte_in;
                        left_q--;
                        if (left_q == 0)
                        begin
                            if (phase_q == BODY_FIXED)
                            begin
                                phase_q      = BODY_IDLE;
                                r.end_status = hcbd_pkg::STAT_COMPLETE;
                            end
                            else
                            begin
                                phase_q = TRAIL_CR;
                            end
                        end
                    end
                    LINE_LEAD, LINE_HEX:
                    begin
                        r.end_status = size_line_byte(it.byte_in);
                    end
                    TRAIL_CR:
                    begin
                        cr_q    = (it.byte_in == hcbd_pkg::CHAR_CR);
                        phase_q = TRAIL_LF;
                    end
                    TRAIL_LF:
                    begin
                        if (cr_q && it.byte_in == hcbd_pkg::CHAR_LF)
                        begin
                            open_size_line();
                        end
                        else
                        begin
                            phase_q      = BODY_IDLE;
                            r.end_status = hcbd_pkg::STAT_NO_CRLF;
                        end
                    end
                    default:
                    begin
                        r.end_status = hcbd_pkg::STAT_NO_MSG;
                    end
                endcase
            end
            default:
            begin
                // unused mode: no state change, all-zero result
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_q       = BODY_IDLE;
            line_cnt_q    = 0;
            cr_q          = 1'b0;
            stopped_q     = 1'b0;
            size_q        = '0;
            left_q        = '0;
            due_results.delete();
            fail_count    = 0;
            pending       = 0;
            items_seen    = 0;
            payload_seen  = 0;
            complete_seen = 0;
            error_seen    = 0;
        end
        else
        begin
            // results leave only after their transaction has passed through the DUT registers, so check first
            if (result.valid && result.ready)
            begin
                got.payload_valid = result.payload_valid;
                got.payload_byte  = result.payload_byte;
                got.end_status    = result.end_status;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result valid=%0b byte=%02h st=%0d",
                                 $time, got.payload_valid, got.payload_byte, got.end_status);
                    end
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.payload_valid !== want.payload_valid
                        || got.payload_byte !== want.payload_byte
                        || got.end_status !== want.end_status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp valid=%0b byte=%02h st=%0d", $time,
                                     want.payload_valid, want.payload_byte, want.end_status);
                            $display("    got valid=%0b byte=%02h st=%0d",
                                     got.payload_valid, got.payload_byte, got.end_status);
                        end
                    end
                    if (want.payload_valid)
                    begin
                        payload_seen++;
                    end
                    if (want.end_status == hcbd_pkg::STAT_COMPLETE)
                    begin
                        complete_seen++;
                    end
                    else if (want.end_status != hcbd_pkg::STAT_CONT)
                    begin
                        error_seen++;
                    end
                end
            end
            if (stream.valid && stream.ready)
            begin
                taken.mode        = stream.mode;
                taken.byte_in     = stream.byte_in;
                taken.body_length = stream.body_length;
                due_results.push_back(deframe_step(taken));
                items_seen++;
            end
            pending = due_results.size();
        end
    end

endmodule

// File: dv/tb_http_chunked_body_decoder.sv
module tb_http_chunked_body_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT  = 64;
    localparam int SIZE_BITS   = 32;
    localparam int ITEM_TARGET = 820;
    localparam int HOLD_CYCLES = 300;

    localparam int MODE_W   = hcbd_pkg::MODE_W;
    localparam int BYTE_W   = hcbd_pkg::BYTE_W;
    localparam int LENGTH_W = hcbd_pkg::LENGTH_W;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    logic clk;
    logic rst_n;

    bit steady;
    bit hold_req;
    int items_sent;

    int fail_count;
    int pending;
    int items_seen;
    int payload_seen;
    int complete_seen;
    int error_seen;

    hcbd_stream_if stream_ch();
    hcbd_result_if result_ch();

    http_chunked_body_decoder #(
        .LINE_LIMIT (LINE_LIMIT),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch.sink),
        .result (result_ch.source)
    );

    hcbd_body_checker #(
        .LINE_LIMIT (LINE_LIMIT),
        .SIZE_BITS  (SIZE_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream        (stream_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_seen    (items_seen),
        .payload_seen  (payload_seen),
        .complete_seen (complete_seen),
        .error_seen    (error_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
                             input logic [LENGTH_W-1:0] len);
        while (!steady && $urandom_range(99) < 15)
        begin
            stream_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.mode        <= m;
        stream_ch.byte_in     <= b;
        stream_ch.body_length <= len;
        @(posedge clk);
        while (!stream_ch.ready)
        begin
            @(posedge clk);
        end
        if (m != MODE_NONE)
        begin
            items_sent++;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(hcbd_pkg::MODE_BYTE, b, LENGTH_W'($urandom));
    endtask

    task automatic open_fixed(input logic [LENGTH_W-1:0] len);
        send_item(hcbd_pkg::MODE_FIXED, BYTE_W'($urandom), len);
    endtask

    task automatic open_chunked();
        send_item(hcbd_pkg::MODE_CHUNKED, BYTE_W'($urandom), LENGTH_W'($urandom));
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + BYTE_W'(nib);
        end
        return ($urandom_range(1) ? 8'h61 : 8'h41) + BYTE_W'(nib) - 8'd10;
    endfunction

    // hex digits of value (top digit first), optionally with leading blanks and an extension
    task automatic send_size_line(input logic [47:0] value, input int ndigits, input bit decorate);
        int lead;
        lead = decorate ? $urandom_range(2) : 0;
        repeat (lead)
        begin
            case ($urandom_range(4))
                0: send_byte(hcbd_pkg::CHAR_SP);
                1: send_byte(hcbd_pkg::CHAR_TAB);
                2: send_byte(hcbd_pkg::CHAR_VT);
                3: send_byte(hcbd_pkg::CHAR_FF);
                default: send_byte(hcbd_pkg::CHAR_LF);
            endcase
        end
        for (int i = ndigits - 1; i >= 0; i--)
        begin
            send_byte(hex_char(value[4*i +: 4]));
        end
        if (decorate && $urandom_range(3) == 0)
        begin
            send_byte(8'h3B);
            repeat ($urandom_range(5))
            begin
                send_byte(BYTE_W'($urandom_range(8'h67, 8'h7A)));
            end
        end
        send_byte(hcbd_pkg::CHAR_CR);
        send_byte(hcbd_pkg::CHAR_LF);
    endtask

    task automatic send_chunk(input int size, input bit good_trailer);
        int nd;
        logic [BYTE_W-1:0] t0;
        logic [BYTE_W-1:0] t1;
        nd = 1;
        while ((size >> (4 * nd)) != 0)
        begin
            nd++;
        end
        send_size_line(48'(size), nd + $urandom_range(2), 1'b1);
        repeat (size)
        begin
            send_byte(BYTE_W'($urandom));
        end
        if (good_trailer)
        begin
            send_byte(hcbd_pkg::CHAR_CR);
            send_byte(hcbd_pkg::CHAR_LF);
        end
        else
        begin
            t0 = $urandom_range(1) ? hcbd_pkg::CHAR_CR : BYTE_W'($urandom);
            t1 = BYTE_W'($urandom);
            if (t0 == hcbd_pkg::CHAR_CR && t1 == hcbd_pkg::CHAR_LF)
            begin
                t1 = hcbd_pkg::CHAR_CR;
            end
            send_byte(t0);
            send_byte(t1);
        end
    endtask

    // receiver: random back-pressure plus one long hold while the sender keeps going
    initial
    begin
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        bit drained;
        int kind;
        int len;
        int nd;
        logic [47:0] big;
        logic [BYTE_W-1:0] b;

        rst_n                 <= 1'b0;
        stream_ch.valid       <= 1'b0;
        stream_ch.mode        <= hcbd_pkg::MODE_BYTE;
        stream_ch.byte_in     <= '0;
        stream_ch.body_length <= '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte with no open message, unused mode, empty and endless fixed bodies
        send_byte(8'hFF);
        send_item(MODE_NONE, 8'hFF, '1);
        open_fixed('0);
        open_fixed('1);
        send_byte(8'h00);
        send_byte(8'hFF);
        // reopening drops the endless body
        open_fixed(LENGTH_W'(1));
        send_byte(8'hA5);
        // one two-byte chunk, terminating zero chunk, then a trailer byte
        open_chunked();
        send_byte(hcbd_pkg::CHAR_SP);
        send_byte(8'h32);
        send_byte(8'h3B);
        send_byte(hcbd_pkg::CHAR_CR);
        send_byte(hcbd_pkg::CHAR_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hcbd_pkg::CHAR_CR);
        send_byte(hcbd_pkg::CHAR_LF);
        send_byte(8'h30);
        send_byte(hcbd_pkg::CHAR_CR);
        send_byte(hcbd_pkg::CHAR_LF);
        send_byte(8'h78);

        drained = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 450 && items_sent < 600);
            if (items_sent >= 150)
            begin
                hold_req = 1'b1;
            end
            if (!drained && items_sent >= 300)
            begin
                // let the block drain completely before carrying on
                drained = 1'b1;
                stream_ch.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending != 0);
            end
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                open_chunked();
                repeat ($urandom_range(1, 3))
                begin
                    send_chunk(($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                       : $urandom_range(1, 8), 1'b1);
                end
                send_size_line('0, 1 + $urandom_range(2), 1'b1);
                if ($urandom_range(1))
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        send_byte(BYTE_W'($urandom));
                    end
                end
            end
            else if (kind < 60)
            begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
                open_fixed(LENGTH_W'(len));
                // sometimes cut short so the next open drops it
                if ($urandom_range(7) == 0)
                begin
                    len = $urandom_range(len);
                end
                repeat (len)
                begin
                    send_byte(BYTE_W'($urandom));
                end
            end
            else if (kind < 68)
            begin
                // size line that never ends
                open_chunked();
                repeat (LINE_LIMIT + $urandom_range(3))
                begin
                    b = BYTE_W'($urandom);
                    if (b == hcbd_pkg::CHAR_CR)
                    begin
                        b = 8'h47;
                    end
                    send_byte(b);
                end
            end
            else if (kind < 76)
            begin
                open_chunked();
                if ($urandom_range(1))
                begin
                    send_chunk($urandom_range(1, 6), 1'b1);
                end
                send_chunk($urandom_range(1, 6), 1'b0);
            end
            else if (kind < 82)
            begin
                // oversized chunk size, abandoned after a few data bytes
                open_chunked();
                big = {16'($urandom), 32'($urandom)};
                nd = $urandom_range(8, 12);
                big[4*(nd-1) +: 4] = 4'hF;
                send_size_line(big, nd, 1'b0);
                repeat (3)
                begin
                    send_byte(BYTE_W'($urandom));
                end
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(4, 12))
                begin
                    case ($urandom_range(3))
                        0: open_chunked();
                        1: open_fixed(LENGTH_W'($urandom_range(3)));
                        2: open_fixed(LENGTH_W'($urandom));
                        default: send_byte(BYTE_W'($urandom));
                    endcase
                end
            end
            else if (kind < 95)
            begin
                // size line from a mix of blanks, digits and stray characters
                open_chunked();
                repeat ($urandom_range(3, 10))
                begin
                    case ($urandom_range(7))
                        0: send_byte(hcbd_pkg::CHAR_SP);
                        1: send_byte(hcbd_pkg::CHAR_CR);
                        2: send_byte(hcbd_pkg::CHAR_LF);
                        3: send_byte(hcbd_pkg::CHAR_TAB);
                        4: send_byte(BYTE_W'($urandom_range(8'h30, 8'h39)));
                        5: send_byte(BYTE_W'($urandom_range(8'h61, 8'h66)));
                        6: send_byte(8'h67);
                        default: send_byte(8'h3B);
                    endcase
                end
            end
            else
            begin
                send_item(MODE_NONE, BYTE_W'($urandom), LENGTH_W'($urandom));
                send_byte(BYTE_W'($urandom));
            end
        end

        stream_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d input transactions: %0d payload bytes, %0d bodies completed",
                 items_seen, payload_seen, complete_seen);
        $display("%0d bodies ended on an error or stray-byte status", error_seen);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
